// ===== design/gwfm_pkg.sv =====
// Package for the windowed Goertzel magnitude detector.
// Holds widths, reset values and register index codes shared by the interfaces and the top level.
// No dependencies.
package gwfm_pkg;

    // fixed-point and field widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int SAMPLE_W      = 10;
    localparam int MAG_W         = 16;
    localparam int DELAY_W       = 32;
    localparam int TWO_COS_W     = 19;
    localparam int TRIG_W        = 18;
    localparam int WIN_LEN_W     = 13;
    localparam int POS_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 19;

    // register reset values
    localparam logic signed [TWO_COS_W-1:0] TWO_COS_RST = '0;
    localparam logic signed [TRIG_W-1:0]    COS_RST     = TRIG_W'(65536);
    localparam logic signed [TRIG_W-1:0]    SIN_RST     = '0;
    localparam logic [WIN_LEN_W-1:0]        WIN_LEN_RST = WIN_LEN_W'(256);
    localparam logic [WIN_LEN_W-1:0]        WIN_MAX     = WIN_LEN_W'(4096);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TWO_COS = 2'd0,
        CFG_COS     = 2'd1,
        CFG_SIN     = 2'd2,
        CFG_WIN_LEN = 2'd3
    } t_cfg_reg;

endpackage

// ===== design/gwfm_if.sv =====
// Channel interfaces of the windowed Goertzel magnitude detector:
// sample stream, result stream and configuration write channel.
// Depends on gwfm_pkg.
interface gwfm_in_if;
    import gwfm_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface gwfm_out_if;
    import gwfm_pkg::*;
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnitude_estimate;
    logic             window_end;

    modport source (output valid, output magnitude_estimate, output window_end, input ready);
    modport sink   (input valid, input magnitude_estimate, input window_end, output ready);
endinterface

interface gwfm_cfg_if;
    import gwfm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/goertzel_windowed_fixed_magnitude.sv =====
// Windowed fixed-point Goertzel tone detector with alpha-max-plus-beta-min magnitude.
// Depends on gwfm_pkg and the channel interfaces in gwfm_if.sv.
//
// Usage:
//   i_sample carries one 10-bit unsigned converter sample per request.
//   o_result carries one magnitude estimate and a window-end flag per sample.
//   i_cfg writes the coefficient and window-length registers; it is always ready.
//   Registers are to be written by the user only while no sample is in flight; the block does not enforce it.
// Path: a sample accepted into the input register passes the middle and result
//   registers before it is on o_result.
// Throughput: one sample per cycle while o_result is not stalled. The Goertzel recursion (one multiply and a
//   three-term add) closes combinationally between the input register and the
//   delay registers; the magnitude follows in the next stage.
// Stalls: each of the three stages holds its item while the one after it is
//   full, so the input keeps taking samples until all stages are occupied.
// Reset: the delays and the window position clear, the coefficients go to
//   2cos = 0, cos = 1.0, sin = 0 and the window length to 256, and all stages empty.
// On the last sample of a window the result uses the running delays, then
//   both delays clear; the window position wraps and never restarts otherwise.
module goertzel_windowed_fixed_magnitude #(
    parameter int FRAC_BITS = gwfm_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gwfm_in_if.sink            i_sample,
    gwfm_cfg_if.sink           i_cfg,
    gwfm_out_if.source         o_result
);
    import gwfm_pkg::*;

    localparam int FB_W   = TWO_COS_W + DELAY_W;  // feedback product width
    localparam int TP_W   = TRIG_W + DELAY_W;     // cos/sin product width
    localparam int RE_W   = TP_W + 1;
    localparam int MAG_FW = RE_W + 1;

    // configuration registers
    logic signed [TWO_COS_W-1:0] r_two_cos;
    logic signed [TRIG_W-1:0]    r_cos;
    logic signed [TRIG_W-1:0]    r_sin;
    logic [WIN_LEN_W-1:0]        r_win_len;

    // recursion state
    logic signed [DELAY_W-1:0] r_newest;
    logic signed [DELAY_W-1:0] r_older;
    logic [POS_W-1:0]          r_pos;

    // pipeline registers
    logic                      r_a_valid;
    logic [SAMPLE_W-1:0]       r_a_sample;
    logic                      r_m_valid;
    logic signed [DELAY_W-1:0] r_m_q0;
    logic signed [TP_W-1:0]    r_m_pc;
    logic signed [TP_W-1:0]    r_m_ps;
    logic                      r_m_end;
    logic                      r_o_valid;
    logic [MAG_W-1:0]          r_o_mag;
    logic                      r_o_end;

    // handshake
    logic acc_in, acc_cfg, out_rdy, mid_rdy, a_rdy, mv_a, mv_m;

    // recursion datapath
    logic [DELAY_W-1:0]        smp_shift;
    logic signed [FB_W-1:0]    p_fb;
    logic signed [FB_W-1:0]    fb_sh;
    logic [DELAY_W-1:0]        n_newest;
    logic signed [TP_W-1:0]    p_cos;
    logic signed [TP_W-1:0]    p_sin;
    logic [WIN_LEN_W-1:0]      len_c;
    logic                      win_end;

    // magnitude datapath
    logic signed [TP_W-1:0]    pc_sh;
    logic signed [TP_W-1:0]    im;
    logic signed [RE_W-1:0]    re;
    logic [RE_W-1:0]           ar;
    logic [TP_W-1:0]           ai;
    logic [RE_W-1:0]           mn;
    logic [MAG_FW-1:0]         mag;

    // stage readiness, back to front
    assign out_rdy        = !r_o_valid || o_result.ready;
    assign mid_rdy        = !r_m_valid || out_rdy;
    assign a_rdy          = !r_a_valid || mid_rdy;
    assign i_sample.ready = a_rdy;
    assign acc_in         = i_sample.valid && a_rdy;
    assign mv_a           = r_a_valid && mid_rdy;
    assign mv_m           = r_m_valid && out_rdy;

    assign i_cfg.ready    = 1'b1;
    assign acc_cfg        = i_cfg.valid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_cos <= TWO_COS_RST;
            r_cos     <= COS_RST;
            r_sin     <= SIN_RST;
            r_win_len <= WIN_LEN_RST;
        end else if (acc_cfg) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_TWO_COS: r_two_cos <= i_cfg.data[TWO_COS_W-1:0];
                CFG_COS:     r_cos     <= i_cfg.data[TRIG_W-1:0];
                CFG_SIN:     r_sin     <= i_cfg.data[TRIG_W-1:0];
                CFG_WIN_LEN: r_win_len <= i_cfg.data[WIN_LEN_W-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_rdy) begin
            r_a_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_a_sample <= i_sample.adc_sample;
        end
    end

    // goertzel recursion: q0 = (sample << (F-2)) + (2cos*q1 >> F) - q2, wrapping
    assign smp_shift = DELAY_W'(r_a_sample) << (FRAC_BITS - 2);
    assign p_fb      = r_two_cos * r_newest;
    assign fb_sh     = p_fb >>> FRAC_BITS;
    assign n_newest  = smp_shift + DELAY_W'(fb_sh) - r_older;

    // output products use the pre-update newest delay as q2
    assign p_cos = r_newest * r_cos;
    assign p_sin = r_newest * r_sin;

    // window length clamped to 1..4096
    always_comb begin
        priority if (r_win_len == '0) begin
            len_c = WIN_LEN_W'(1);
        end else if (r_win_len > WIN_MAX) begin
            len_c = WIN_MAX;
        end else begin
            len_c = r_win_len;
        end
    end

    assign win_end = {1'b0, r_pos} >= (len_c - WIN_LEN_W'(1));

    // state update as a sample leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_older  <= '0;
            r_pos    <= '0;
        end else if (mv_a) begin
            if (win_end) begin
                r_newest <= '0;
                r_older  <= '0;
                r_pos    <= '0;
            end else begin
                r_newest <= n_newest;
                r_older  <= r_newest;
                r_pos    <= r_pos + POS_W'(1);
            end
        end
    end

    // middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (mid_rdy) begin
            r_m_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv_a) begin
            r_m_q0  <= n_newest;
            r_m_pc  <= p_cos;
            r_m_ps  <= p_sin;
            r_m_end <= win_end;
        end
    end

    // magnitude: |re| + |im| - min/2, kept wide
    assign pc_sh = r_m_pc >>> FRAC_BITS;
    assign im    = r_m_ps >>> FRAC_BITS;
    assign re    = RE_W'(r_m_q0) - RE_W'(pc_sh);
    assign ar    = re[RE_W-1] ? RE_W'(-re) : RE_W'(re);
    assign ai    = im[TP_W-1] ? TP_W'(-im) : TP_W'(im);
    assign mn    = (ar < RE_W'(ai)) ? ar : RE_W'(ai);
    assign mag   = MAG_FW'(ar) + MAG_FW'(ai) - MAG_FW'(mn >> 1);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_rdy) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv_m) begin
            r_o_mag <= mag[FRAC_BITS +: MAG_W];
            r_o_end <= r_m_end;
        end
    end

    assign o_result.valid              = r_o_valid;
    assign o_result.magnitude_estimate = r_o_mag;
    assign o_result.window_end         = r_o_end;

    // delays and position clear after a window closes
    a_window_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv_a && win_end) |=> (r_newest == '0 && r_older == '0 && r_pos == '0))
        else $error("delays not cleared after window end");

    // recursion state moves only when a sample is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mv_a |=> ($stable(r_newest) && $stable(r_older) && $stable(r_pos)))
        else $error("recursion state changed without a sample");

    // a sample leaving the middle stage shows up as a result
    a_mid_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv_m |=> r_o_valid)
        else $error("result lost between middle and output stage");

endmodule

// ===== sim/tb_goertzel_windowed_fixed_magnitude.sv =====
// Testbench for the windowed Goertzel magnitude detector: drives sample and config requests,
// predicts every magnitude and window flag in a scoreboard class and checks them in order.
// Depends on gwfm_pkg, the channel interfaces and goertzel_windowed_fixed_magnitude.
module tb_goertzel_windowed_fixed_magnitude;
    timeunit 1ns;
    timeprecision 1ps;
    import gwfm_pkg::*;

    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int PHASES    = 8;
    localparam int PER_PHASE = 225;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             window_end;
    } t_tone_result;

    // goertzel predictor with its own delays, window position and coefficients
    class goertzel_scoreboard;
        logic signed [TWO_COS_W-1:0] two_cos;
        logic signed [TRIG_W-1:0]    cos_q;
        logic signed [TRIG_W-1:0]    sin_q;
        logic [WIN_LEN_W-1:0]        win_len;
        logic [DELAY_W-1:0]          q1;
        logic [DELAY_W-1:0]          q2;
        logic [POS_W-1:0]            pos;
        t_tone_result                expected_q[$];
        int unsigned                 fail_count;
        int unsigned                 checked;

        function new();
            two_cos    = TWO_COS_RST;
            cos_q      = COS_RST;
            sin_q      = SIN_RST;
            win_len    = WIN_LEN_RST;
            q1         = '0;
            q2         = '0;
            pos        = '0;
            fail_count = 0;
            checked    = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_TWO_COS: two_cos = value[TWO_COS_W-1:0];
                CFG_COS:     cos_q   = value[TRIG_W-1:0];
                CFG_SIN:     sin_q   = value[TRIG_W-1:0];
                CFG_WIN_LEN: win_len = value[WIN_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        // run one recursion step and queue the expected result
        function void note_sample(logic [SAMPLE_W-1:0] sample);
            longint signed feedback;
            longint signed s1;
            longint signed s2;
            longint signed re;
            longint signed im;
            longint signed ar;
            longint signed ai;
            longint signed mn;
            longint signed mag;
            logic [DELAY_W-1:0] q0;
            int unsigned len;
            t_tone_result r;

            feedback = (longint'(two_cos) * longint'(signed'(q1))) >>> FRAC;
            q0 = (DELAY_W'(sample) << (FRAC - 2)) + DELAY_W'(feedback) - q2;
            q2 = q1;
            q1 = q0;

            // magnitude in wide arithmetic, only the shifted value is truncated
            s1  = longint'(signed'(q1));
            s2  = longint'(signed'(q2));
            re  = s1 - ((s2 * longint'(cos_q)) >>> FRAC);
            im  = (s2 * longint'(sin_q)) >>> FRAC;
            ar  = (re < 0) ? -re : re;
            ai  = (im < 0) ? -im : im;
            mn  = (ar < ai) ? ar : ai;
            mag = ar + ai - (mn >>> 1);
            r.magnitude = MAG_W'(mag >>> FRAC);

            // zero length acts as one, long lengths saturate
            len = win_len;
            if (len == 0) len = 1;
            if (len > WIN_MAX) len = WIN_MAX;
            r.window_end = (32'(pos) >= len - 1);
            if (r.window_end) begin
                q1  = '0;
                q2  = '0;
                pos = '0;
            end else begin
                pos = pos + 1'b1;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [MAG_W-1:0] magnitude, logic window_end);
            t_tone_result r;
            checked++;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result mag=%0d window_end=%0b",
                             $realtime, magnitude, window_end);
                return;
            end
            r = expected_q.pop_front();
            if (r.magnitude !== magnitude || r.window_end !== window_end) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result %0d wrong: mag exp %0d got %0d, end exp %0b got %0b",
                             $realtime, checked, r.magnitude, magnitude,
                             r.window_end, window_end);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gwfm_in_if  sample_if ();
    gwfm_cfg_if cfg_if ();
    gwfm_out_if result_if ();

    goertzel_scoreboard board;

    goertzel_windowed_fixed_magnitude u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // overall time limit
    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            board.check_result(result_if.magnitude_estimate, result_if.window_end);
    end

    // result ready pattern, with one long hold-off to back up the pipeline
    initial begin : result_sink
        int unsigned cyc;
        int unsigned hold_cycles;
        int          mode;
        bit          held;
        cyc         = 0;
        hold_cycles = 0;
        mode        = 0;
        held        = 1'b0;
        result_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (!held && board.checked >= 760) begin
                held        = 1'b1;
                hold_cycles = 400;
            end
            if (cyc % 50 == 0) mode = $urandom_range(0, 3);
            if (hold_cycles > 0) begin
                hold_cycles--;
                result_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0: result_if.ready <= 1'b1;
                    1: result_if.ready <= ($urandom_range(0, 3) != 0);
                    2: result_if.ready <= (cyc % 3 != 0);
                    default: result_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one sample request, held until accepted
    task automatic send_sample(logic [SAMPLE_W-1:0] sample);
        @(negedge i_clk);
        sample_if.valid      <= 1'b1;
        sample_if.adc_sample <= sample;
        do @(posedge i_clk); while (!sample_if.ready);
        board.note_sample(sample);
    endtask

    // one register write request
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        board.write_reg(idx, value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // stop sending and wait for the pipeline to empty
    task automatic drain_results();
        @(negedge i_clk);
        sample_if.valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_all(int two_cos_v, int cos_v, int sin_v, int len_v);
        write_reg(CFG_TWO_COS, CFG_DATA_W'(two_cos_v));
        write_reg(CFG_COS, CFG_DATA_W'(cos_v));
        write_reg(CFG_SIN, CFG_DATA_W'(sin_v));
        write_reg(CFG_WIN_LEN, CFG_DATA_W'(len_v));
    endtask

    // random coefficients with the extremes favored, window lengths mostly short
    task automatic randomize_config();
        int two_cos_v;
        int cos_v;
        int sin_v;
        int len_v;
        case ($urandom_range(0, 3))
            0: two_cos_v = -131072;
            1: two_cos_v = 131072;
            default: two_cos_v = int'($urandom_range(0, 262144)) - 131072;
        endcase
        case ($urandom_range(0, 3))
            0: cos_v = -65536;
            1: cos_v = 65536;
            default: cos_v = int'($urandom_range(0, 131072)) - 65536;
        endcase
        case ($urandom_range(0, 3))
            0: sin_v = -65536;
            1: sin_v = 65536;
            default: sin_v = int'($urandom_range(0, 131072)) - 65536;
        endcase
        case ($urandom_range(0, 9))
            0: len_v = 0;
            1: len_v = 4096;
            2: len_v = $urandom_range(4097, 8191);
            3, 4, 5, 6: len_v = $urandom_range(1, 16);
            default: len_v = $urandom_range(17, 300);
        endcase
        write_all(two_cos_v, cos_v, sin_v, len_v);
    endtask

    // main stimulus
    initial begin : stimulus
        logic [SAMPLE_W-1:0] reset_run[8];
        logic [SAMPLE_W-1:0] sample;
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        bit          steady;

        reset_run = '{10'd0, 10'd1023, 10'd1023, 10'd512, 10'd1, 10'd2, 10'd4, 10'd8};
        board = new();
        i_rst_n              = 1'b0;
        sample_if.valid      = 1'b0;
        sample_if.adc_sample = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_TWO_COS;
        cfg_if.data          = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients, sample extremes and single bits
        foreach (reset_run[i]) send_sample(reset_run[i]);
        drain_results();

        // window shortened below the running position ends at once
        write_all(131072, -65536, 65536, 4);
        repeat (3) send_sample(10'd1023);
        drain_results();

        // zero window length acts as one
        write_all(-131072, 65536, -65536, 0);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1023);
        drain_results();

        // window length beyond the maximum saturates
        write_all(131071, 65535, 65535, 8191);
        repeat (4) send_sample(10'd1023);
        drain_results();

        // random phases, each under fresh coefficients
        for (int phase = 0; phase < PHASES; phase++) begin
            randomize_config();
            steady = (phase == 2);
            sent   = 0;
            while (sent < PER_PHASE) begin
                burst = $urandom_range(1, 32);
                for (int k = 0; k < burst && sent < PER_PHASE; k++) begin
                    if ($urandom_range(0, 7) == 0)
                        sample = $urandom_range(0, 1) ? '1 : '0;
                    else
                        sample = SAMPLE_W'($urandom);
                    send_sample(sample);
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0 || steady) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    @(negedge i_clk);
                    sample_if.valid <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            drain_results();
        end

        // settle, then report
        repeat (8) @(posedge i_clk);
        if (board.outstanding() != 0) board.fail_count++;
        if (board.fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gwfm_pkg.sv
design/gwfm_if.sv
design/goertzel_windowed_fixed_magnitude.sv
sim/tb_goertzel_windowed_fixed_magnitude.sv
